// ===== src/lfu_pkg.sv =====
// Shared types and constants for the LFU cache table.
package lfu_pkg;

	localparam int  MAX_ENTRIES_DEF = 16;
	localparam int  CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;
	localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

	// one request word
	typedef struct packed {
		logic               kind;
		logic signed [31:0] lookup_key;
		logic signed [31:0] store_value;
	} lfu_req_t;

	// one result word
	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} lfu_rsp_t;

	// one stored table entry
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
		logic [31:0] use_count;
		logic [63:0] stamp;
	} lfu_entry_t;

	// scan outcome flags
	typedef struct packed {
		logic match;
		logic free;
		logic victim;
	} lfu_scan_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} lfu_state_t;

endpackage

// ===== src/lfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/lfu_scan.sv =====
// Per-entry compare unit: key match, first free slot and LFU/LRU victim tracking.
module lfu_scan
	import lfu_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clr,
	input  logic            en,
	input  logic [IDX_W-1:0] idx,
	input  logic            slot_vld,
	input  lfu_entry_t      ent,
	input  logic [31:0]     key,
	output lfu_scan_flags_t flags,
	output logic [IDX_W-1:0] match_idx,
	output lfu_entry_t      match_ent,
	output logic [IDX_W-1:0] free_idx,
	output logic [IDX_W-1:0] vic_idx,
	output logic [31:0]     vic_key
);

	lfu_scan_flags_t  flags_q;
	logic [IDX_W-1:0] match_idx_q, free_idx_q, vic_idx_q;
	lfu_entry_t       match_ent_q;
	logic [31:0]      vic_key_q, vic_cnt_q;
	logic [63:0]      vic_stamp_q;
	logic             is_match, is_free, better;

	// compare against the current entry
	always_comb begin
		is_match = slot_vld && (ent.key == key) && !flags_q.match;
		is_free  = !slot_vld && !flags_q.free;
		better   = slot_vld && (!flags_q.victim || (ent.use_count < vic_cnt_q) ||
			((ent.use_count == vic_cnt_q) && (ent.stamp < vic_stamp_q)));
	end

	// flag tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else if (en) begin
			if (is_match) flags_q.match  <= 1'b1;
			if (is_free)  flags_q.free   <= 1'b1;
			if (better)   flags_q.victim <= 1'b1;
		end
	end

	// captured entry data
	always_ff @(posedge clk) begin
		if (en) begin
			if (is_match) begin
				match_idx_q <= idx;
				match_ent_q <= ent;
			end
			if (is_free) begin
				free_idx_q <= idx;
			end
			if (better) begin
				vic_idx_q   <= idx;
				vic_key_q   <= ent.key;
				vic_cnt_q   <= ent.use_count;
				vic_stamp_q <= ent.stamp;
			end
		end
	end

	assign flags     = flags_q;
	assign match_idx = match_idx_q;
	assign match_ent = match_ent_q;
	assign free_idx  = free_idx_q;
	assign vic_idx   = vic_idx_q;
	assign vic_key   = vic_key_q;

endmodule

// ===== src/lfu_cache_table_top.sv =====
// Top level of the LFU cache table with LRU tie break.
//
// Usage: drive req and raise start while busy is low; the word is taken at
// that clock edge and busy rises. Each request (get or put) returns exactly
// one result word on rsp, marked by done for a single cycle; the receiver
// must take it then, there is no backpressure.
// The table RAM has one read port, so the scan reads one entry per cycle
// through the compare unit; then a drain state empties the read pipe and a
// commit state writes the update. done and the result word are registered
// from the commit state. A new request can be accepted in the cycle done is
// high, so requests never overlap: busy stays high until the commit.
// cfg_we/cfg_wdata write the capacity register (reset 16); write it only
// while busy is low. Values above MAX_ENTRIES act as MAX_ENTRIES, zero makes
// puts do nothing.
// Reset (arst_n low) clears all valid bits, the occupancy, the touch clock
// and the sequencer; RAM contents are left as they are and never used while
// their valid bit is clear.
module lfu_cache_table_top
	import lfu_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lfu_req_t         req,
	output logic             busy,
	output logic             done,
	output lfu_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CW-1:0]    MAX_CW   = CW'(MAX_ENTRIES);

	lfu_state_t state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic [OCC_W-1:0]  occ_q;
	logic [63:0]       clock_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	lfu_req_t          req_q;
	lfu_rsp_t          rsp_q;
	logic              done_q;

	logic [IDX_W-1:0]  rd_idx_q, cmp_idx_s1;
	logic              cmp_vld_s1;
	lfu_entry_t        rd_ent;

	lfu_scan_flags_t   flags;
	logic [IDX_W-1:0]  match_idx, free_idx, vic_idx;
	lfu_entry_t        match_ent;
	logic [31:0]       vic_key;

	logic              scan_clr, scan_step, commit;
	logic [CW-1:0]     cap_eff, occ_cw;
	logic [63:0]       stamp_new;
	logic [31:0]       cnt_new;
	logic              do_touch, do_evict, do_store, use_vic;
	logic [IDX_W-1:0]  store_idx;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	lfu_entry_t        wdata;
	lfu_rsp_t          rsp_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		scan_clr  = 1'b0;
		scan_step = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					scan_clr = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_step = 1'b1;
				if (rd_idx_q == LAST_IDX) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				commit  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// scan read pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= scan_step;
			if (scan_clr) begin
				rd_idx_q <= '0;
			end else if (scan_step && rd_idx_q != LAST_IDX) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
		if (start && !busy) begin
			req_q <= req;
		end
	end

	lfu_ram #(
		.WIDTH($bits(lfu_entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx_q),
		.rdata (rd_ent)
	);

	lfu_scan #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (scan_clr),
		.en        (cmp_vld_s1),
		.idx       (cmp_idx_s1),
		.slot_vld  (valid_q[cmp_idx_s1]),
		.ent       (rd_ent),
		.key       (req_q.lookup_key),
		.flags     (flags),
		.match_idx (match_idx),
		.match_ent (match_ent),
		.free_idx  (free_idx),
		.vic_idx   (vic_idx),
		.vic_key   (vic_key)
	);

	// commit decision
	always_comb begin
		cap_eff   = (CW'(cap_q) > MAX_CW) ? MAX_CW : CW'(cap_q);
		occ_cw    = CW'(occ_q);
		stamp_new = clock_q + 64'd1;
		cnt_new   = (match_ent.use_count == CNT_MAX) ? CNT_MAX :
			match_ent.use_count + 32'd1;
		do_touch  = 1'b0;
		do_evict  = 1'b0;
		do_store  = 1'b0;
		we        = 1'b0;
		waddr     = match_idx;
		wdata     = match_ent;
		rsp_d.hit         = 1'b0;
		rsp_d.read_value  = READ_MISS;
		rsp_d.evicted     = 1'b0;
		rsp_d.evicted_key = '0;
		use_vic   = 1'b0;
		store_idx = free_idx;
		if (req_q.kind == KIND_GET) begin
			if (flags.match) begin
				do_touch         = 1'b1;
				rsp_d.hit        = 1'b1;
				rsp_d.read_value = match_ent.value;
				wdata            = '{key: match_ent.key, value: match_ent.value,
					use_count: cnt_new, stamp: stamp_new};
			end
		end else if (cap_eff != '0) begin
			if (flags.match) begin
				do_touch  = 1'b1;
				rsp_d.hit = 1'b1;
				wdata     = '{key: match_ent.key, value: req_q.store_value,
					use_count: cnt_new, stamp: stamp_new};
			end else begin
				do_evict = (occ_cw >= cap_eff) && flags.victim;
				// the evicted slot becomes the lowest free one if it sits below
				use_vic   = do_evict && (!flags.free || (vic_idx < free_idx));
				store_idx = use_vic ? vic_idx : free_idx;
				do_store  = do_evict || flags.free;
				do_touch  = do_store;
				waddr     = store_idx;
				wdata     = '{key: req_q.lookup_key, value: req_q.store_value,
					use_count: 32'd1, stamp: stamp_new};
				rsp_d.evicted     = do_evict;
				rsp_d.evicted_key = do_evict ? vic_key : '0;
			end
		end
		we = commit && do_touch;
	end

	// table state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			occ_q   <= '0;
			clock_q <= '0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= commit;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (commit) begin
				if (do_touch) clock_q <= stamp_new;
				// a reused victim slot stays valid with the new entry
				if (do_evict && !use_vic) valid_q[vic_idx] <= 1'b0;
				if (do_store) valid_q[store_idx] <= 1'b1;
				if (do_store && !do_evict) occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== test/lfu_cache_table_checker.sv =====
// Result checker for the LFU cache table: tracks the table contents and compares every result word.
`timescale 1ns / 1ps
module lfu_cache_table_checker
	import lfu_pkg::*;
#(
	parameter int DEPTH = MAX_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  lfu_req_t         req,
	input  logic             done,
	input  lfu_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output int               errors,
	output int               pending
);

	// shadow copy of the table
	logic             slot_used [DEPTH];
	logic [31:0]      slot_tag  [DEPTH];
	logic [31:0]      slot_data [DEPTH];
	logic [31:0]      slot_uses [DEPTH];
	logic [63:0]      slot_age  [DEPTH];
	logic [63:0]      touch_ctr;
	int               fill;
	logic [CAP_W-1:0] capacity;
	int               mismatches;

	// result words still owed by the block, oldest first
	lfu_rsp_t awaited_words [$];

	// bump use count (saturating) and restamp
	function automatic void touch_slot(int s);
		if (slot_uses[s] != CNT_MAX)
			slot_uses[s]++;
		touch_ctr++;
		slot_age[s] = touch_ctr;
	endfunction

	// apply one get/put to the shadow table and return the word it yields
	function automatic lfu_rsp_t serve_request(lfu_req_t r);
		lfu_rsp_t w;
		int       cap;
		int       found;
		int       victim;
		int       free_slot;
		int       i;
		w.hit         = 1'b0;
		w.read_value  = READ_MISS;
		w.evicted     = 1'b0;
		w.evicted_key = '0;
		cap = (capacity > DEPTH) ? DEPTH : int'(capacity);
		found = -1;
		for (i = 0; i < DEPTH; i++)
			if (found < 0 && slot_used[i] && slot_tag[i] == r.lookup_key)
				found = i;

		if (r.kind == KIND_GET) begin
			if (found >= 0) begin
				touch_slot(found);
				w.hit        = 1'b1;
				w.read_value = slot_data[found];
			end
		end else if (cap != 0) begin
			if (found >= 0) begin
				touch_slot(found);
				slot_data[found] = r.store_value;
				w.hit = 1'b1;
			end else begin
				// full (or over-full after a capacity drop): drop one entry first
				if (fill >= cap) begin
					victim = -1;
					for (i = 0; i < DEPTH; i++) begin
						if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
								(slot_uses[i] == slot_uses[victim] &&
								 slot_age[i] < slot_age[victim])))
							victim = i;
					end
					if (victim >= 0) begin
						w.evicted     = 1'b1;
						w.evicted_key = slot_tag[victim];
						slot_used[victim] = 1'b0;
						if (fill > 0)
							fill--;
					end
				end
				// new entry goes to the lowest free slot
				free_slot = -1;
				for (i = 0; i < DEPTH; i++)
					if (free_slot < 0 && !slot_used[i])
						free_slot = i;
				if (free_slot >= 0) begin
					slot_used[free_slot] = 1'b1;
					slot_tag[free_slot]  = r.lookup_key;
					slot_data[free_slot] = r.store_value;
					slot_uses[free_slot] = 32'd1;
					touch_ctr++;
					slot_age[free_slot]  = touch_ctr;
					fill++;
				end
			end
		end
		return w;
	endfunction

	// compare finished words first, then predict the word accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		lfu_rsp_t want;
		int       i;
		if (!arst_n) begin
			for (i = 0; i < DEPTH; i++)
				slot_used[i] = 1'b0;
			touch_ctr  = '0;
			fill       = 0;
			capacity   = CAP_RESET;
			mismatches = 0;
			awaited_words.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (done !== 1'b0) begin
				if (awaited_words.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result word with nothing outstanding: hit=%0b read=%h ev=%0b evkey=%h",
							$time, rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
					mismatches++;
				end else begin
					want = awaited_words.pop_front();
					if (rsp.hit !== want.hit || rsp.read_value !== want.read_value ||
							rsp.evicted !== want.evicted || rsp.evicted_key !== want.evicted_key) begin
						if (mismatches < 10)
							$display("%0t: word mismatch: want hit=%0b read=%h ev=%0b evkey=%h, got hit=%0b read=%h ev=%0b evkey=%h",
								$time, want.hit, want.read_value, want.evicted, want.evicted_key,
								rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				awaited_words.push_back(serve_request(req));
			if (cfg_we)
				capacity = cfg_wdata;
			errors  <= mismatches;
			pending <= awaited_words.size();
		end
	end

endmodule

// ===== test/lfu_cache_table_top_tb.sv =====
// Testbench top for the LFU cache table: drives get/put words and capacity writes, gives the verdict.
`timescale 1ns / 1ps
module lfu_cache_table_top_tb;
	import lfu_pkg::*;

	localparam int DEPTH       = MAX_ENTRIES_DEF;
	localparam int LATENCY     = DEPTH + 3;
	localparam int POOL        = 24;
	localparam int PHASE_WORDS = 50;
	localparam int PHASES      = 10;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             done;
	lfu_req_t         req;
	lfu_rsp_t         rsp;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               errors;
	int               pending;

	int          burst_left;
	int          eff_cap;
	logic [31:0] key_pool [POOL];

	lfu_cache_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lfu_cache_table_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// hand one word over at a falling edge, then pace bursts and gaps
	task automatic send_word(logic kind, logic [31:0] key, logic [31:0] value);
		lfu_req_t w;
		w.kind        = kind;
		w.lookup_key  = key;
		w.store_value = value;
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 8);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	endtask

	// capacity write, only once the block has answered everything
	task automatic write_capacity(logic [CAP_W-1:0] v);
		start <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we  <= 1'b0;
		eff_cap = (v > DEPTH) ? DEPTH : int'(v);
	endtask

	initial begin
		int          caps [PHASES];
		int          span;
		logic        kind;
		logic [31:0] key;
		logic [31:0] value;

		caps       = '{1, 16, 31, 5, 0, 2, 9, 17, 3, 16};
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		burst_left = 1;
		eff_cap    = DEPTH;

		// key pool: extremes first, then random keys
		key_pool[0] = 32'h7FFF_FFFF;
		key_pool[1] = 32'h8000_0000;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[3] = 32'h0000_0000;
		for (int i = 4; i < POOL; i++)
			key_pool[i] = $urandom();
		caps[8] = $urandom_range(1, 15);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, value of all ones on a hit, put hit
		write_capacity(5'd16);
		send_word(KIND_GET, 32'h0000_0000, 32'h1234_5678);
		send_word(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
		send_word(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(KIND_PUT, 32'h7FFF_FFFF, 32'd12345);
		send_word(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(KIND_GET, 32'h8000_0000, 32'h0);
		send_word(KIND_GET, 32'd1, 32'h0);

		// capacity dropped below occupancy: each new key evicts one, LRU breaks count ties
		write_capacity(5'd2);
		send_word(KIND_PUT, 32'd7, 32'hA5A5_A5A5);
		send_word(KIND_PUT, 32'd8, 32'h5A5A_5A5A);
		send_word(KIND_GET, 32'd8, 32'h0);
		send_word(KIND_PUT, 32'd9, 32'h0000_0009);

		// zero capacity: puts do nothing, gets still hit
		write_capacity(5'd0);
		send_word(KIND_PUT, 32'd100, 32'd100);
		send_word(KIND_GET, 32'd8, 32'h0);
		send_word(KIND_PUT, 32'd8, 32'd1);

		// capacity above the table size acts as a full table
		write_capacity(5'd31);
		for (int i = 0; i < 8; i++)
			send_word(KIND_PUT, 32'd200 + i, $urandom());

		// random phases, keys mostly from a pool a bit larger than the capacity
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(caps[p][CAP_W-1:0]);
			span = eff_cap + $urandom_range(1, 4);
			if (span > POOL)
				span = POOL;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				kind  = ($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET;
				key   = ($urandom_range(0, 9) == 0) ? $urandom() :
					key_pool[$urandom_range(0, span - 1)];
				value = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom();
				send_word(kind, key, value);
			end
		end

		// drain, then give late or extra words time to show up
		start <= 1'b0;
		wait (pending == 0);
		repeat (2 * LATENCY) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== lfu_cache_table_top.f =====
src/lfu_pkg.sv
src/lfu_ram.sv
src/lfu_scan.sv
src/lfu_cache_table_top.sv
test/lfu_cache_table_checker.sv
test/lfu_cache_table_top_tb.sv
